>>> hw/rtl/pwt_pkg.sv
// Package for the peer weight table: sizes, operation, status and register
// codes, sequencer states and the weight clamping helper.
// Used by peer_weight_table_core and its port checks; depends on nothing.
package pwt_pkg;

  localparam int CAPACITY = 64;
  localparam int ID_WIDTH = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int W_W      = 24;
  localparam logic [W_W-1:0] WMAX = '1;

  typedef enum logic [2:0] {
    OP_GET       = 3'd0,
    OP_SET       = 3'd1,
    OP_REMOVE    = 3'd2,
    OP_REINFORCE = 3'd3,
    OP_DECAY     = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_MAX_ENTRIES    = 2'd0,
    REG_DECAY_MULT     = 2'd1,
    REG_MIN_WEIGHT     = 2'd2,
    REG_INITIAL_WEIGHT = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVSCAN,
    S_SHIFT,
    S_INSERT,
    S_DECAY,
    S_RESP
  } state_t;

  // Clamp a signed value to the unsigned Q8.16 range.
  function automatic logic [W_W-1:0] clamp_w(input logic signed [W_W+1:0] v);
    logic [W_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({2'b00, WMAX})) begin
      r = WMAX;
    end else begin
      r = v[W_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/peer_weight_table_core.sv
// Peer weight table: id and weight memories with a sequencer that scans,
// compacts, evicts and decays entries. Depends on pwt_pkg.
//
// Usage. Input transactions (operation, peer_id, amount) are taken on
// in_valid/in_ready; one result transaction (found, weight_out, status,
// entry_count) leaves on out_valid/out_ready for every input. Registers are
// to be written through cfg_we/cfg_index/cfg_data only while the block is
// idle; the block itself does not enforce this. A lookup walks the stored
// entries one per cycle through the registered read port of the memories.
// Remove adds a compaction pass over the entries above the slot. An insert
// into a capped, full table adds a lowest-weight scan and a compaction pass.
// Decay walks one entry per cycle through the read, multiply and write-back
// stages. One transaction is worked on at a time; the next is taken in the
// cycle after the result is registered, even while that result is still
// waiting in the output register.
// Reset clears the entry count, the handshakes and the registers but for the
// decay multiplier, which returns to 17'h10000; the memories need no clearing
// as only slots below the count are read. When the receiver stalls, the
// finished result holds and the sequencer waits before writing the next one.
module peer_weight_table_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    operation,
  input  logic [63:0]                   peer_id,
  input  logic signed [24:0]            amount,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic [23:0]                   weight_out,
  output logic [1:0]                    status,
  output logic [6:0]                    entry_count,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [23:0]                   cfg_data
);
  import pwt_pkg::*;

  logic [ID_WIDTH-1:0] id_mem [CAPACITY];
  logic [W_W-1:0]      wt_mem [CAPACITY];

  logic [6:0]     max_entries;
  logic [16:0]    decay_mult;
  logic [W_W-1:0] min_weight;
  logic [W_W-1:0] initial_weight;

  state_t state, state_next;
  logic [2:0]               op_r;
  logic [ID_WIDTH-1:0]      id_r;
  logic signed [24:0]       amt_r;
  logic [CNT_W-1:0]         rd_idx, rd_idx_next;
  logic                     pend, pend_next;
  logic [IDX_W-1:0]         pend_idx, pend_idx_next;
  logic                     pend2, pend2_next;
  logic [IDX_W-1:0]         pend2_idx, pend2_idx_next;
  logic [W_W+16:0]          prod;
  logic [IDX_W-1:0]         low_idx, low_idx_next;
  logic [W_W-1:0]           low_w, low_w_next;
  logic [CNT_W-1:0]         slot, slot_next;
  logic [W_W-1:0]           ins_w, ins_w_next;
  logic                     ins_pend, ins_pend_next;
  logic [CNT_W-1:0]         count, count_next;
  logic                     res_found, res_found_next;
  logic [W_W-1:0]           res_w, res_w_next;
  status_t                  res_status, res_status_next;

  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic [ID_WIDTH-1:0] id_rd;
  logic [W_W-1:0]      wt_rd;
  logic                id_we, wt_we;
  logic [IDX_W-1:0]    wr_addr;
  logic [ID_WIDTH-1:0] wr_id;
  logic [W_W-1:0]      wr_wt;

  logic             hit;
  logic [W_W-1:0]   reinf_w;
  logic [W_W-1:0]   ins_val;
  logic [W_W-1:0]   decay_w;
  logic [W_W+16:0]  prod_next;
  logic [IDX_W-1:0] low_cand;
  logic [W_W-1:0]   low_cand_w;
  logic             evict;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (id_we) begin
      id_mem[wr_addr] <= wr_id;
    end
    if (wt_we) begin
      wt_mem[wr_addr] <= wr_wt;
    end
    if (rd_en) begin
      id_rd <= id_mem[rd_addr];
      wt_rd <= wt_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries    <= '0;
      decay_mult     <= 17'h10000;
      min_weight     <= '0;
      initial_weight <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_MAX_ENTRIES:    max_entries    <= cfg_data[6:0];
        REG_DECAY_MULT:     decay_mult     <= cfg_data[16:0];
        REG_MIN_WEIGHT:     min_weight     <= cfg_data;
        REG_INITIAL_WEIGHT: initial_weight <= cfg_data;
      endcase
    end
  end

  // Combinational helpers used by several states.
  always_comb begin
    logic [W_W:0] shifted;
    hit     = pend && (id_rd == id_r);
    reinf_w = clamp_w($signed({2'b00, wt_rd}) + 26'(amt_r));
    if (reinf_w < min_weight) begin
      reinf_w = min_weight;
    end
    if (op_r == OP_SET) begin
      ins_val = clamp_w(26'(amt_r));
    end else if (amt_r > $signed({1'b0, initial_weight})) begin
      ins_val = clamp_w(26'(amt_r));
    end else begin
      ins_val = initial_weight;
    end
    prod_next = (W_W + 17)'(wt_rd) * (W_W + 17)'(decay_mult);
    shifted   = prod[W_W+16:16];
    decay_w   = shifted[W_W] ? WMAX : shifted[W_W-1:0];
    if (decay_w < min_weight) begin
      decay_w = min_weight;
    end
    if (pend && (pend_idx == '0 || wt_rd < low_w)) begin
      low_cand   = pend_idx;
      low_cand_w = wt_rd;
    end else begin
      low_cand   = low_idx;
      low_cand_w = low_w;
    end
    evict = (max_entries != '0) && (32'(count) >= 32'(max_entries)) && (count != '0);
  end

  always_comb begin
    state_next      = state;
    rd_idx_next     = rd_idx;
    pend_next       = 1'b0;
    pend_idx_next   = pend_idx;
    pend2_next      = 1'b0;
    pend2_idx_next  = pend2_idx;
    low_idx_next    = low_idx;
    low_w_next      = low_w;
    slot_next       = slot;
    ins_w_next      = ins_w;
    ins_pend_next   = ins_pend;
    count_next      = count;
    res_found_next  = res_found;
    res_w_next      = res_w;
    res_status_next = res_status;
    rd_en   = 1'b0;
    rd_addr = rd_idx[IDX_W-1:0];
    id_we   = 1'b0;
    wt_we   = 1'b0;
    wr_addr = slot[IDX_W-1:0];
    wr_id   = id_r;
    wr_wt   = wt_rd;

    unique case (state)
      S_IDLE: begin
        rd_idx_next     = '0;
        ins_pend_next   = 1'b0;
        res_found_next  = 1'b0;
        res_w_next      = '0;
        res_status_next = ST_OK;
        if (in_valid) begin
          priority if (operation == OP_DECAY) begin
            state_next = S_DECAY;
          end else if (operation <= OP_REINFORCE) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_RESP;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          res_found_next = 1'b1;
          slot_next      = CNT_W'(pend_idx);
          wr_addr        = pend_idx;
          state_next     = S_RESP;
          unique case (op_r)
            OP_GET: res_w_next = wt_rd;
            OP_SET: begin
              wt_we      = 1'b1;
              wr_wt      = clamp_w(26'(amt_r));
              res_w_next = clamp_w(26'(amt_r));
            end
            OP_REMOVE: begin
              res_w_next  = min_weight;
              rd_idx_next = CNT_W'(pend_idx) + 1'b1;
              state_next  = S_SHIFT;
            end
            default: begin
              wt_we      = 1'b1;
              wr_wt      = reinf_w;
              res_w_next = reinf_w;
            end
          endcase
        end else if (rd_idx >= count) begin
          rd_idx_next = '0;
          unique case (op_r)
            OP_GET: begin
              res_w_next = min_weight;
              state_next = S_RESP;
            end
            OP_REMOVE: begin
              res_w_next      = min_weight;
              res_status_next = ST_MISSING;
              state_next      = S_RESP;
            end
            default: begin
              ins_w_next    = ins_val;
              ins_pend_next = 1'b1;
              state_next    = evict ? S_EVSCAN : S_INSERT;
            end
          endcase
        end else begin
          rd_en         = 1'b1;
          rd_idx_next   = rd_idx + 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = rd_idx[IDX_W-1:0];
        end
      end

      // Lowest weight wins; the strict compare keeps the earliest on ties.
      S_EVSCAN: begin
        low_idx_next = low_cand;
        low_w_next   = low_cand_w;
        if (rd_idx >= count) begin
          slot_next   = CNT_W'(low_cand);
          rd_idx_next = CNT_W'(low_cand) + 1'b1;
          state_next  = S_SHIFT;
        end else begin
          rd_en         = 1'b1;
          rd_idx_next   = rd_idx + 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = rd_idx[IDX_W-1:0];
        end
      end

      // Each entry above the removed slot moves down by one.
      S_SHIFT: begin
        if (pend) begin
          id_we   = 1'b1;
          wt_we   = 1'b1;
          wr_addr = pend_idx - 1'b1;
          wr_id   = id_rd;
        end
        if (rd_idx >= count) begin
          count_next = count - 1'b1;
          state_next = ins_pend ? S_INSERT : S_RESP;
        end else begin
          rd_en         = 1'b1;
          rd_idx_next   = rd_idx + 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = rd_idx[IDX_W-1:0];
        end
      end

      S_INSERT: begin
        state_next = S_RESP;
        if (32'(count) >= CAPACITY) begin
          res_status_next = ST_FULL;
          res_w_next      = min_weight;
        end else begin
          id_we      = 1'b1;
          wt_we      = 1'b1;
          wr_addr    = count[IDX_W-1:0];
          wr_wt      = ins_w;
          count_next = count + 1'b1;
          res_w_next = ins_w;
        end
      end

      // Read, multiply and write back, one entry per cycle.
      S_DECAY: begin
        if (pend2) begin
          wt_we   = 1'b1;
          wr_addr = pend2_idx;
          wr_wt   = decay_w;
        end
        pend2_next     = pend;
        pend2_idx_next = pend_idx;
        if (rd_idx < count) begin
          rd_en         = 1'b1;
          rd_idx_next   = rd_idx + 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = rd_idx[IDX_W-1:0];
        end else if (!pend && !pend2) begin
          state_next = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      pend2     <= 1'b0;
      ins_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      pend     <= pend_next;
      pend2    <= pend2_next;
      ins_pend <= ins_pend_next;
      if (state == S_RESP && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_r  <= operation;
      id_r  <= peer_id[ID_WIDTH-1:0];
      amt_r <= amount;
    end
    rd_idx     <= rd_idx_next;
    pend_idx   <= pend_idx_next;
    pend2_idx  <= pend2_idx_next;
    prod       <= prod_next;
    low_idx    <= low_idx_next;
    low_w      <= low_w_next;
    slot       <= slot_next;
    ins_w      <= ins_w_next;
    res_found  <= res_found_next;
    res_w      <= res_w_next;
    res_status <= res_status_next;
    if (state == S_RESP && (!out_valid || out_ready)) begin
      found       <= res_found;
      weight_out  <= res_w;
      status      <= res_status;
      entry_count <= 7'(count);
    end
  end

endmodule

>>> hw/rtl/pwt_checker.sv
// Port-level checks for the peer weight table and their binding to
// peer_weight_table_core. Depends on pwt_pkg.
module pwt_port_checks (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic [2:0]          operation,
  input logic [63:0]         peer_id,
  input logic signed [24:0]  amount,
  input logic                out_valid,
  input logic                out_ready,
  input logic                found,
  input logic [23:0]         weight_out,
  input logic [1:0]          status,
  input logic [6:0]          entry_count,
  input logic                cfg_we,
  input logic [1:0]          cfg_index,
  input logic [23:0]         cfg_data
);
  import pwt_pkg::*;

  // A result transaction held back by the receiver stays valid and keeps its weight and status.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(weight_out) && $stable(status))
    else $error("result changed while stalled");

  // A failed remove or a dropped insert never reports the peer as found.
  a_status_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_MISSING || status == ST_FULL) |-> !found)
    else $error("error status with found set");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_FULL)
    else $error("undefined status code");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(entry_count) <= CAPACITY)
    else $error("entry count above capacity");

endmodule

bind peer_weight_table_core pwt_port_checks u_pwt_port_checks (.*);

>>> verif/pwt_checker.sv
`timescale 1ns / 1ps
// Checker for the peer weight table: watches both channels and the register
// port, predicts each result from its own table copy and compares it.
// Depends on pwt_pkg.
module pwt_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [63:0] peer_id,
  input  logic [24:0] amount,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        found,
  input  logic [23:0] weight_out,
  input  logic [1:0]  status,
  input  logic [6:0]  entry_count,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  import pwt_pkg::*;

  typedef struct packed {
    logic        found;
    logic [23:0] weight;
    logic [1:0]  status;
    logic [6:0]  count;
  } table_result_t;

  table_result_t expected_results[$];

  logic [6:0]  cap_entries;
  logic [16:0] factor;
  logic [23:0] floor_w;
  logic [23:0] start_w;
  logic [63:0] ids[CAPACITY];
  logic [23:0] weights[CAPACITY];
  int          n_stored;

  function automatic logic [23:0] sat_w(longint v);
    if (v < 0) return 24'd0;
    if (v > 64'hFFFFFF) return 24'hFFFFFF;
    return v[23:0];
  endfunction

  function automatic int lookup(logic [63:0] id);
    for (int i = 0; i < n_stored; i++)
      if (ids[i] == id) return i;
    return -1;
  endfunction

  function automatic void close_gap(int slot);
    for (int i = slot; i < n_stored - 1; i++) begin
      ids[i] = ids[i+1];
      weights[i] = weights[i+1];
    end
    n_stored--;
  endfunction

  // Evicts the earliest lowest weight when capped and at or above the cap.
  function automatic bit place(logic [63:0] id, logic [23:0] w);
    int low;
    if (cap_entries != 0 && n_stored >= cap_entries && n_stored > 0) begin
      low = 0;
      for (int i = 1; i < n_stored; i++)
        if (weights[i] < weights[low]) low = i;
      close_gap(low);
    end
    if (n_stored >= CAPACITY) return 0;
    ids[n_stored] = id;
    weights[n_stored] = w;
    n_stored++;
    return 1;
  endfunction

  function automatic table_result_t apply_op(logic [2:0] op, logic [63:0] id,
                                             logic [24:0] amt);
    table_result_t r;
    longint        delta;
    longint        prod;
    int            slot;
    logic [23:0]   w;
    r = '0;
    delta = longint'($signed(amt));
    case (op)
      OP_GET: begin
        slot = lookup(id);
        if (slot >= 0) begin
          r.found = 1;
          r.weight = weights[slot];
        end else r.weight = floor_w;
      end
      OP_SET: begin
        slot = lookup(id);
        w = sat_w(delta);
        if (slot >= 0) begin
          r.found = 1;
          weights[slot] = w;
          r.weight = w;
        end else if (place(id, w)) r.weight = w;
        else begin
          r.status = ST_FULL;
          r.weight = floor_w;
        end
      end
      OP_REMOVE: begin
        slot = lookup(id);
        if (slot >= 0) begin
          r.found = 1;
          close_gap(slot);
        end else r.status = ST_MISSING;
        r.weight = floor_w;
      end
      OP_REINFORCE: begin
        slot = lookup(id);
        if (slot >= 0) begin
          r.found = 1;
          w = sat_w(longint'(weights[slot]) + delta);
          if (w < floor_w) w = floor_w;
          weights[slot] = w;
          r.weight = w;
        end else begin
          w = sat_w(delta > longint'(start_w) ? delta : longint'(start_w));
          if (place(id, w)) r.weight = w;
          else begin
            r.status = ST_FULL;
            r.weight = floor_w;
          end
        end
      end
      OP_DECAY: begin
        for (int i = 0; i < n_stored; i++) begin
          prod = (longint'(weights[i]) * longint'(factor)) >>> 16;
          w = sat_w(prod);
          if (w < floor_w) w = floor_w;
          weights[i] = w;
        end
      end
      default: ;
    endcase
    r.count = n_stored[6:0];
    return r;
  endfunction

  always @(posedge clk) begin
    table_result_t exp_r;
    if (rst) begin
      cap_entries <= '0;
      factor <= 17'd65536;
      floor_w <= '0;
      start_w <= '0;
      n_stored = 0;
      expected_results.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_MAX_ENTRIES:    cap_entries <= cfg_data[6:0];
          REG_DECAY_MULT:     factor <= cfg_data[16:0];
          REG_MIN_WEIGHT:     floor_w <= cfg_data;
          REG_INITIAL_WEIGHT: start_w <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_results.push_back(apply_op(operation, peer_id, amount));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: found %0b weight %h status %0d count %0d",
                   $realtime, found, weight_out, status, entry_count);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r != {found, weight_out, status, entry_count}) begin
            $display("%0t: mismatch expected found %0b weight %h status %0d count %0d",
                     $realtime, exp_r.found, exp_r.weight, exp_r.status, exp_r.count);
            $display("%0t:            actual found %0b weight %h status %0d count %0d",
                     $realtime, found, weight_out, status, entry_count);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_results.size();
    end
  end

endmodule

>>> verif/peer_weight_table_core_test.sv
`timescale 1ns / 1ps
// Top of the peer weight table testbench: clock, reset, register writes and
// operation stimulus in phases, with random gaps and receiver stalls.
// Depends on pwt_pkg, peer_weight_table_core and pwt_checker.
module peer_weight_table_core_test;
  import pwt_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [2:0]  operation = '0;
  logic [63:0] peer_id = '0;
  logic [24:0] amount = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic        found;
  logic [23:0] weight_out;
  logic [1:0]  status;
  logic [6:0]  entry_count;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  bit          hold_off = 0;
  int          stall_left = 0;
  logic [63:0] known_ids[16];

  always #2 clk = ~clk;

  peer_weight_table_core i_dut (.*);

  pwt_checker i_checker (.*);

  function automatic int gap_length();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  // Receiver: mostly short random stalls, now and then a long one, plus a
  // long hold-off when requested.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 0;
    end else if (hold_off) out_ready <= 0;
    else if ($urandom_range(0, 99) == 0) begin
      stall_left <= $urandom_range(20, 60);
      out_ready <= 0;
    end else if ($urandom_range(0, 3) == 0) out_ready <= 0;
    else out_ready <= 1;
  end

  // Driven at the falling edge; a following send may raise valid again in
  // the same step, so blocking assignments are used here.
  task automatic send(logic [2:0] op, logic [63:0] id, logic [24:0] amt);
    in_valid = 1;
    operation = op;
    peer_id = id;
    amount = amt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 0;
    repeat (gap_length()) @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [23:0] val);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (2 * CAPACITY + 20) @(negedge clk);
  endtask

  task automatic set_regs(logic [6:0] cap, logic [16:0] fac, logic [23:0] mw, logic [23:0] iw);
    drain();
    write_reg(REG_MAX_ENTRIES, 24'(cap));
    write_reg(REG_DECAY_MULT, 24'(fac));
    write_reg(REG_MIN_WEIGHT, mw);
    write_reg(REG_INITIAL_WEIGHT, iw);
  endtask

  function automatic logic [24:0] rand_amount();
    case ($urandom_range(0, 5))
      0: return 25'h1000000;
      1: return 25'h0FFFFFF;
      2: return 25'($signed(-$urandom_range(0, 200000)));
      default: return 25'($urandom_range(0, 25'h1FFFFFF));
    endcase
  endfunction

  function automatic logic [2:0] rand_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return OP_GET;
    if (r < 45) return OP_SET;
    if (r < 60) return OP_REMOVE;
    if (r < 92) return OP_REINFORCE;
    if (r < 98) return OP_DECAY;
    return 3'($urandom_range(5, 7));
  endfunction

  // Mostly ids from a small pool so hits and removals are common.
  task automatic random_phase(int n, int pool);
    logic [63:0] id;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 8) id = known_ids[$urandom_range(0, pool - 1)];
      else id = {$urandom, $urandom};
      send(rand_op(), id, rand_amount());
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) known_ids[i] = {$urandom, $urandom};
    known_ids[0] = '0;
    known_ids[1] = '1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed part.
    set_regs(7'd3, 17'd32768, 24'd100, 24'h010000);
    send(OP_GET, known_ids[0], 25'd0);
    send(OP_REMOVE, known_ids[0], 25'd0);
    send(OP_SET, known_ids[0], 25'h1000000);
    send(OP_SET, known_ids[1], 25'h0FFFFFF);
    send(OP_SET, known_ids[2], 25'h1FFFFFF);
    send(OP_REINFORCE, known_ids[2], 25'd50);
    send(OP_REINFORCE, known_ids[1], 25'd1);
    send(OP_REINFORCE, known_ids[1], 25'h1000000);
    send(OP_REINFORCE, known_ids[3], 25'd5);
    send(OP_REINFORCE, known_ids[4], 25'h0FFFFFF);
    send(OP_GET, known_ids[1], 25'd0);
    send(OP_DECAY, '0, 25'd0);
    send(3'd5, known_ids[1], 25'd0);
    send(3'd7, known_ids[1], 25'd0);
    send(OP_REMOVE, known_ids[4], 25'd0);
    send(OP_REMOVE, known_ids[4], 25'd0);

    // No cap: fill to capacity so inserts get dropped.
    set_regs(7'd0, 17'd65536, 24'd0, 24'd0);
    for (int i = 0; i < CAPACITY + 2; i++) send(OP_SET, 64'(i) + 64'h100, 25'(i));
    send(OP_REINFORCE, 64'hDEAD, 25'd1);
    send(OP_DECAY, '0, 25'd0);
    // Receiver holds off while the sender keeps offering.
    hold_off = 1;
    fork
      begin
        repeat (200) @(negedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 8; i++) send(OP_GET, 64'(i) + 64'h100, 25'd0);
    join
    set_regs(7'd64, 17'd65536, 24'd0, 24'd0);
    send(OP_SET, 64'hBEEF, 25'd9);
    // Cap below current count: one eviction per insert.
    set_regs(7'd2, 17'd1, 24'd0, 24'd0);
    send(OP_SET, 64'hF00D, 25'd3);
    send(OP_DECAY, '0, 25'd0);
    for (int i = 0; i < 70; i++) send(OP_REMOVE, 64'(i) + 64'h100, 25'd0);

    set_regs(7'd4, 17'd65535, 24'd0, 24'd256);
    random_phase(150, 8);
    set_regs(7'd64, 17'd98304, 24'hFFFFFF, 24'd0);
    random_phase(60, 16);
    set_regs(7'd0, 17'd0, 24'd1000, 24'hFFFFFF);
    random_phase(100, 16);
    set_regs(7'd10, 17'd60000, 24'd500, 24'd40000);
    random_phase(80, 16);

    drain();
    if (fail_count == 0) $display("** peer_weight_table_core: PASSED **");
    else $display("** peer_weight_table_core: FAILED **");
    $finish;
  end

  initial begin
    #20ms;
    $display("** peer_weight_table_core: FAILED **");
    $finish;
  end

endmodule
